@@ rtl/core/mcsa_pkg.sv @@
// Shared constants, codes and types of the sigma-clipped accumulator.
`timescale 1ns / 1ps
package mcsa_pkg;

  localparam int SAMPLE_W   = 18;
  localparam int FRAC_W     = 8;
  localparam int COUNT_W    = 24;
  localparam int OUT_W      = SAMPLE_W + FRAC_W;
  localparam int STD_W      = OUT_W - 1;
  localparam int INIT_DEPTH = 256;
  localparam int ADDR_W     = 8;
  localparam int FILL_W     = 9;
  localparam int SUM_W      = 42;
  localparam int SQ_W       = 60;
  localparam int BSUM_W     = 26;
  localparam int BSQ_W      = 44;
  localparam int NUM_W      = 82;
  localparam int DEN_W      = 48;
  localparam int QUOT_W     = 64;
  localparam int ROOT_W     = 32;
  localparam int CFG_W      = 18;

  // shared arithmetic unit operand and result widths
  localparam int A_W = NUM_W + 2 * FRAC_W;
  localparam int B_W = DEN_W;
  localparam int R_W = 102;
  localparam int DIV_STEPS  = A_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_INIT = 2'd2;
  localparam logic [1:0] REG_DEVS = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_req_t;

endpackage

@@ rtl/core/mcsa_buf.sv @@
// Calibration sample buffer: one write port, one registered read port.
`timescale 1ns / 1ps
module mcsa_buf (
  input  logic                                clk,
  input  logic                                we,
  input  logic [mcsa_pkg::ADDR_W-1:0]         waddr,
  input  logic signed [mcsa_pkg::SAMPLE_W-1:0] wdata,
  input  logic [mcsa_pkg::ADDR_W-1:0]         raddr,
  output logic signed [mcsa_pkg::SAMPLE_W-1:0] rdata_r
);

  logic signed [mcsa_pkg::SAMPLE_W-1:0] mem [mcsa_pkg::INIT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/core/mcsa_arith.sv @@
// Shared multi-cycle unit: shift-add multiply, restoring divide, integer square root.
`timescale 1ns / 1ps
module mcsa_arith (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcsa_pkg::arith_req_t        req,
  input  logic [mcsa_pkg::A_W-1:0]    a,
  input  logic [mcsa_pkg::B_W-1:0]    b,
  output logic                        done,
  output logic [mcsa_pkg::R_W-1:0]    res
);

  localparam int RW = mcsa_pkg::R_W;
  localparam int BW = mcsa_pkg::B_W;
  localparam int AW = mcsa_pkg::A_W;
  localparam int QW = mcsa_pkg::QUOT_W;
  localparam int TW = mcsa_pkg::ROOT_W + 3;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [RW-1:0] x_r, x_nxt;
  logic [RW-1:0] y_r, y_nxt;
  logic [BW-1:0] z_r, z_nxt;

  logic [BW:0]   drem;
  logic          dge;
  logic [TW-1:0] srem;
  logic [TW-1:0] strial;
  logic          sge;

  always_comb begin
    drem   = {y_r[BW-1:0], x_r[AW-1]};
    dge    = drem >= {1'b0, z_r};
    srem   = {y_r[TW-3:0], x_r[QW-1:QW-2]};
    strial = {1'b0, z_r[mcsa_pkg::ROOT_W-1:0], 2'b01};
    sge    = srem >= strial;

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      y_nxt    = '0;
      unique case (req.op)
        mcsa_pkg::OP_MUL: begin
          x_nxt = RW'(a);
          z_nxt = b;
        end
        mcsa_pkg::OP_DIV: begin
          x_nxt   = RW'(a);
          z_nxt   = b;
          cnt_nxt = 7'(mcsa_pkg::DIV_STEPS);
        end
        default: begin
          x_nxt   = RW'(a[QW-1:0]);
          z_nxt   = '0;
          cnt_nxt = 7'(mcsa_pkg::SQRT_STEPS);
        end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        mcsa_pkg::OP_MUL: begin
          if (z_r == '0) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end else begin
            y_nxt = z_r[0] ? y_r + x_r : y_r;
            x_nxt = {x_r[RW-2:0], 1'b0};
            z_nxt = {1'b0, z_r[BW-1:1]};
          end
        end
        mcsa_pkg::OP_DIV: begin
          y_nxt   = dge ? RW'(drem - {1'b0, z_r}) : RW'(drem);
          x_nxt   = {x_r[RW-2:0], dge};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: begin
          y_nxt   = sge ? RW'(srem - strial) : RW'(srem);
          z_nxt   = {z_r[BW-2:0], sge};
          x_nxt   = {x_r[RW-3:0], 2'b00};
          cnt_nxt = cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= mcsa_pkg::OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign done = done_r;

  always_comb begin
    case (op_r)
      mcsa_pkg::OP_MUL: res = y_r;
      mcsa_pkg::OP_DIV: res = RW'(x_r[AW-1:0]);
      default:          res = RW'(z_r);
    endcase
  end

endmodule

@@ rtl/core/median_clipped_mean_std_accumulator.sv @@
// Top level: sequencer, accumulator state and result register of the clipped accumulator.
`timescale 1ns / 1ps
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_command, in_sample
//  out_    | output    | out_valid/out_stall| counts, mean, std_dev, limits, limits_set
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// For one item the shared unit runs a 98-step divide for the mean and, for sigma,
// three shift-add multiplies, a 98-step divide and a 32-step root; an in-range
// sample is first squared by one more multiply. Finalizing the buffer adds a median
// search over the single read port, the sigma pass and a rescan of the buffer.
// Reset is synchronous on rst_n; the buffer needs no clearing pass.
// in_stall is high from acceptance until the result is in the output register.
module median_clipped_mean_std_accumulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [mcsa_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mcsa_pkg::COUNT_W-1:0]         out_accepted_count,
  output logic [mcsa_pkg::COUNT_W-1:0]         out_rejected_count,
  output logic signed [mcsa_pkg::OUT_W-1:0]    out_mean,
  output logic [mcsa_pkg::STD_W-1:0]           out_std_dev,
  output logic signed [mcsa_pkg::OUT_W-1:0]    out_lower_limit,
  output logic signed [mcsa_pkg::OUT_W-1:0]    out_upper_limit,
  output logic                                 out_limits_set,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [mcsa_pkg::CFG_W-1:0]           cfg_data
);

  localparam int SW  = mcsa_pkg::SAMPLE_W;
  localparam int FW  = mcsa_pkg::FRAC_W;
  localparam int CW  = mcsa_pkg::COUNT_W;
  localparam int OW  = mcsa_pkg::OUT_W;
  localparam int LW  = mcsa_pkg::FILL_W;
  localparam int AW  = mcsa_pkg::A_W;
  localparam int BW  = mcsa_pkg::B_W;
  localparam int RW  = mcsa_pkg::R_W;
  localparam int UW  = mcsa_pkg::SUM_W;
  localparam int QSW = mcsa_pkg::SQ_W;
  localparam int NW  = mcsa_pkg::NUM_W;
  localparam int DW  = mcsa_pkg::DEN_W;
  localparam int TW  = mcsa_pkg::ROOT_W;
  localparam int XW  = OW + 12;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_BW     = 5'd1;
  localparam logic [4:0] S_FIN    = 5'd2;
  localparam logic [4:0] S_MED_A  = 5'd3;
  localparam logic [4:0] S_MED_B  = 5'd4;
  localparam logic [4:0] S_MED_C  = 5'd5;
  localparam logic [4:0] S_MED_D  = 5'd6;
  localparam logic [4:0] S_MED_E  = 5'd7;
  localparam logic [4:0] S_SG_M1G = 5'd8;
  localparam logic [4:0] S_SG_M1W = 5'd9;
  localparam logic [4:0] S_SG_M2G = 5'd10;
  localparam logic [4:0] S_SG_M2W = 5'd11;
  localparam logic [4:0] S_SG_M3G = 5'd12;
  localparam logic [4:0] S_SG_M3W = 5'd13;
  localparam logic [4:0] S_SG_DG  = 5'd14;
  localparam logic [4:0] S_SG_DW  = 5'd15;
  localparam logic [4:0] S_SG_QG  = 5'd16;
  localparam logic [4:0] S_SG_QW  = 5'd17;
  localparam logic [4:0] S_DV_G   = 5'd18;
  localparam logic [4:0] S_DV_W   = 5'd19;
  localparam logic [4:0] S_RS_INI = 5'd20;
  localparam logic [4:0] S_RS_A   = 5'd21;
  localparam logic [4:0] S_RS_B   = 5'd22;
  localparam logic [4:0] S_RS_MW  = 5'd23;
  localparam logic [4:0] S_RS_END = 5'd24;
  localparam logic [4:0] S_AC_G   = 5'd25;
  localparam logic [4:0] S_AC_W   = 5'd26;
  localparam logic [4:0] S_RES    = 5'd27;
  localparam logic [4:0] S_MN_W   = 5'd28;
  localparam logic [4:0] S_SGR    = 5'd29;
  localparam logic [4:0] S_OUT    = 5'd30;

  localparam logic signed [SW-1:0] MIN_RST = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] MAX_RST = {1'b0, {(SW-1){1'b1}}};

  logic [4:0] st_r, st_nxt;

  logic signed [SW-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [8:0]           init_r, init_nxt;
  logic [3:0]           devs_r, devs_nxt;

  logic [LW-1:0]        fill_r, fill_nxt;
  logic                 done_r, done_nxt;
  logic signed [OW-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [CW-1:0]        seen_r, seen_nxt, cnt_r, cnt_nxt;
  logic signed [UW-1:0] sum_r, sum_nxt;
  logic [QSW-1:0]       sq_r, sq_nxt;
  logic signed [mcsa_pkg::BSUM_W-1:0] bsum_r, bsum_nxt;
  logic [mcsa_pkg::BSQ_W-1:0]         bsq_r, bsq_nxt;

  logic signed [SW-1:0] accv_r, accv_nxt, smp_r, smp_nxt, cand_r, cand_nxt;
  logic                 pend_r, pend_nxt;
  logic [LW-1:0]        i_r, i_nxt, j_r, j_nxt, less_r, less_nxt, le_r, le_nxt;

  logic [CW-1:0]        sgn_r, sgn_nxt;
  logic signed [UW-1:0] sgs_r, sgs_nxt;
  logic [QSW-1:0]       sgs2_r, sgs2_nxt;
  logic                 sgfin_r, sgfin_nxt;
  logic [NW-1:0]        num_r, num_nxt;
  logic [DW-1:0]        den_r, den_nxt;
  logic [mcsa_pkg::QUOT_W-1:0] quot_r, quot_nxt;
  logic [TW-1:0]        root_r, root_nxt;
  logic signed [SW-1:0] med_r, med_nxt;
  logic signed [OW-1:0] mean_r, mean_nxt;
  logic [mcsa_pkg::STD_W-1:0] std_r, std_nxt;

  logic                 ov_r, ov_nxt;
  logic [CW-1:0]        o_acc_r, o_acc_nxt, o_rej_r, o_rej_nxt;
  logic signed [OW-1:0] o_mean_r, o_mean_nxt, o_lo_r, o_lo_nxt, o_hi_r, o_hi_nxt;
  logic [mcsa_pkg::STD_W-1:0] o_std_r, o_std_nxt;
  logic                 o_set_r, o_set_nxt;

  mcsa_pkg::arith_req_t req;
  logic [AW-1:0]        op_a;
  logic [BW-1:0]        op_b;
  logic                 ar_done;
  logic [RW-1:0]        ar_res;

  logic                 buf_we;
  logic [mcsa_pkg::ADDR_W-1:0] buf_raddr;
  logic signed [SW-1:0] buf_rdata;

  logic                 in_acc;
  logic [LW-1:0]        eff;
  logic [LW-1:0]        k_half;
  logic [SW-1:0]        mag_in, mag_acc, mag_rd;
  logic [UW-1:0]        mag_sgs, mag_sum;
  logic signed [OW-1:0] q_in, q_rd, medq;
  logic                 rng_in, rng_rd;
  logic [CW:0]          mean_div;
  logic signed [XW-1:0] lo_c, hi_c, delta_x;

  mcsa_buf u_buf (
    .clk     (clk),
    .we      (buf_we),
    .waddr   (fill_r[mcsa_pkg::ADDR_W-1:0]),
    .wdata   (in_sample),
    .raddr   (buf_raddr),
    .rdata_r (buf_rdata)
  );

  mcsa_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (op_a),
    .b     (op_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    if (init_r < 9'd2) begin
      eff = 9'd2;
    end else if (init_r > 9'(mcsa_pkg::INIT_DEPTH)) begin
      eff = 9'(mcsa_pkg::INIT_DEPTH);
    end else begin
      eff = init_r;
    end
    k_half  = {1'b0, fill_r[LW-1:1]};
    mag_in  = in_sample[SW-1] ? SW'(-in_sample) : SW'(in_sample);
    mag_acc = accv_r[SW-1] ? SW'(-accv_r) : SW'(accv_r);
    mag_rd  = buf_rdata[SW-1] ? SW'(-buf_rdata) : SW'(buf_rdata);
    mag_sgs = sgs_r[UW-1] ? UW'(-sgs_r) : UW'(sgs_r);
    mag_sum = sum_r[UW-1] ? UW'(-sum_r) : UW'(sum_r);
    q_in    = {in_sample, {FW{1'b0}}};
    q_rd    = {buf_rdata, {FW{1'b0}}};
    medq    = {med_r, {FW{1'b0}}};
    rng_in  = (q_in > low_r) && (q_in < high_r);
    rng_rd  = (q_rd > low_r) && (q_rd < high_r);
    mean_div = {1'b0, cnt_r} >> 1;
    delta_x = XW'(signed'({1'b0, ar_res[35:0]}));
    lo_c    = XW'(medq) - delta_x;
    hi_c    = XW'(medq) + delta_x;
  end

  // sequencer and all state updates
  always_comb begin
    st_nxt   = st_r;
    min_nxt  = min_r;   max_nxt  = max_r;
    init_nxt = init_r;  devs_nxt = devs_r;
    fill_nxt = fill_r;  done_nxt = done_r;
    low_nxt  = low_r;   high_nxt = high_r;
    seen_nxt = seen_r;  cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;   sq_nxt   = sq_r;
    bsum_nxt = bsum_r;  bsq_nxt  = bsq_r;
    accv_nxt = accv_r;  smp_nxt  = smp_r;  cand_nxt = cand_r;
    pend_nxt = pend_r;
    i_nxt    = i_r;     j_nxt    = j_r;
    less_nxt = less_r;  le_nxt   = le_r;
    sgn_nxt  = sgn_r;   sgs_nxt  = sgs_r;  sgs2_nxt = sgs2_r;  sgfin_nxt = sgfin_r;
    num_nxt  = num_r;   den_nxt  = den_r;  quot_nxt = quot_r;  root_nxt  = root_r;
    med_nxt  = med_r;   mean_nxt = mean_r; std_nxt  = std_r;
    ov_nxt   = ov_r && out_stall;
    o_acc_nxt = o_acc_r;  o_rej_nxt = o_rej_r;  o_mean_nxt = o_mean_r;
    o_std_nxt = o_std_r;  o_lo_nxt  = o_lo_r;   o_hi_nxt   = o_hi_r;
    o_set_nxt = o_set_r;
    req.start = 1'b0;
    req.op    = mcsa_pkg::OP_MUL;
    op_a      = '0;
    op_b      = '0;
    buf_we    = 1'b0;
    buf_raddr = i_r[mcsa_pkg::ADDR_W-1:0];

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcsa_pkg::REG_MIN: begin
          min_nxt = cfg_data[SW-1:0];
          if (!done_r) low_nxt = {cfg_data[SW-1:0], {FW{1'b0}}};
        end
        mcsa_pkg::REG_MAX: begin
          max_nxt = cfg_data[SW-1:0];
          if (!done_r) high_nxt = {cfg_data[SW-1:0], {FW{1'b0}}};
        end
        mcsa_pkg::REG_INIT: init_nxt = cfg_data[8:0];
        default:            devs_nxt = cfg_data[3:0];
      endcase
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          accv_nxt = in_sample;
          smp_nxt  = in_sample;
          pend_nxt = 1'b0;
          if (in_command) begin
            st_nxt = done_r ? S_RES : S_FIN;
          end else begin
            if (seen_r != mcsa_pkg::COUNT_MAX) seen_nxt = seen_r + CW'(1);
            if (!rng_in) begin
              st_nxt = S_RES;
            end else if (!done_r && fill_r >= eff) begin
              pend_nxt = 1'b1;
              st_nxt   = S_FIN;
            end else if (done_r) begin
              st_nxt = S_AC_G;
            end else begin
              buf_we    = 1'b1;
              fill_nxt  = fill_r + LW'(1);
              req.start = 1'b1;
              op_a      = AW'(mag_in);
              op_b      = BW'(mag_in);
              st_nxt    = S_BW;
            end
          end
        end
      end
      S_BW: begin
        if (ar_done) begin
          bsum_nxt = bsum_r + mcsa_pkg::BSUM_W'(accv_r);
          bsq_nxt  = bsq_r + ar_res[mcsa_pkg::BSQ_W-1:0];
          st_nxt   = S_RES;
        end
      end
      S_FIN: begin
        i_nxt  = '0;
        st_nxt = (fill_r >= LW'(2)) ? S_MED_A : S_RS_INI;
      end
      // median: count how many entries lie below and at each candidate
      S_MED_A: st_nxt = S_MED_B;
      S_MED_B: begin
        cand_nxt = buf_rdata;
        j_nxt    = '0;
        less_nxt = '0;
        le_nxt   = '0;
        st_nxt   = S_MED_C;
      end
      S_MED_C: begin
        buf_raddr = j_r[mcsa_pkg::ADDR_W-1:0];
        st_nxt    = S_MED_D;
      end
      S_MED_D: begin
        if (buf_rdata < cand_r)  less_nxt = less_r + LW'(1);
        if (buf_rdata <= cand_r) le_nxt   = le_r + LW'(1);
        j_nxt  = j_r + LW'(1);
        st_nxt = (j_r == fill_r - LW'(1)) ? S_MED_E : S_MED_C;
      end
      S_MED_E: begin
        if (less_r <= k_half && le_r > k_half) begin
          med_nxt   = cand_r;
          sgn_nxt   = CW'(fill_r);
          sgs_nxt   = UW'(bsum_r);
          sgs2_nxt  = QSW'(bsq_r);
          sgfin_nxt = 1'b1;
          st_nxt    = S_SG_M1G;
        end else begin
          i_nxt  = i_r + LW'(1);
          st_nxt = S_MED_A;
        end
      end
      S_SG_M1G: begin
        req.start = 1'b1;
        op_a      = AW'(sgs2_r);
        op_b      = BW'(sgn_r);
        st_nxt    = S_SG_M1W;
      end
      S_SG_M1W: begin
        if (ar_done) begin
          num_nxt = ar_res[NW-1:0];
          st_nxt  = S_SG_M2G;
        end
      end
      S_SG_M2G: begin
        req.start = 1'b1;
        op_a      = AW'(mag_sgs);
        op_b      = BW'(mag_sgs);
        st_nxt    = S_SG_M2W;
      end
      S_SG_M2W: begin
        if (ar_done) begin
          num_nxt = num_r - ar_res[NW-1:0];
          st_nxt  = S_SG_M3G;
        end
      end
      S_SG_M3G: begin
        req.start = 1'b1;
        op_a      = AW'(sgn_r);
        op_b      = BW'(sgn_r - CW'(1));
        st_nxt    = S_SG_M3W;
      end
      S_SG_M3W: begin
        if (ar_done) begin
          den_nxt = ar_res[DW-1:0];
          st_nxt  = S_SG_DG;
        end
      end
      S_SG_DG: begin
        req.start = 1'b1;
        req.op    = mcsa_pkg::OP_DIV;
        op_a      = {num_r, {(2*FW){1'b0}}};
        op_b      = den_r;
        st_nxt    = S_SG_DW;
      end
      S_SG_DW: begin
        if (ar_done) begin
          quot_nxt = ar_res[mcsa_pkg::QUOT_W-1:0];
          st_nxt   = S_SG_QG;
        end
      end
      S_SG_QG: begin
        req.start = 1'b1;
        req.op    = mcsa_pkg::OP_SQRT;
        op_a      = AW'(quot_r);
        st_nxt    = S_SG_QW;
      end
      S_SG_QW: begin
        if (ar_done) begin
          root_nxt = ar_res[TW-1:0];
          if (sgfin_r) begin
            st_nxt = S_DV_G;
          end else begin
            std_nxt = (ar_res[TW-1:mcsa_pkg::STD_W] != '0) ? '1
                                                           : ar_res[mcsa_pkg::STD_W-1:0];
            st_nxt  = S_OUT;
          end
        end
      end
      S_DV_G: begin
        req.start = 1'b1;
        op_a      = AW'(root_r);
        op_b      = BW'(devs_r);
        st_nxt    = S_DV_W;
      end
      // narrow only, never widen
      S_DV_W: begin
        if (ar_done) begin
          if (lo_c > XW'(low_r))  low_nxt  = lo_c[OW-1:0];
          if (hi_c < XW'(high_r)) high_nxt = hi_c[OW-1:0];
          st_nxt = S_RS_INI;
        end
      end
      S_RS_INI: begin
        cnt_nxt = '0;
        sum_nxt = '0;
        sq_nxt  = '0;
        i_nxt   = '0;
        st_nxt  = (fill_r == '0) ? S_RS_END : S_RS_A;
      end
      S_RS_A: st_nxt = S_RS_B;
      S_RS_B: begin
        if (rng_rd && cnt_r != mcsa_pkg::COUNT_MAX) begin
          accv_nxt  = buf_rdata;
          req.start = 1'b1;
          op_a      = AW'(mag_rd);
          op_b      = BW'(mag_rd);
          st_nxt    = S_RS_MW;
        end else begin
          i_nxt  = i_r + LW'(1);
          st_nxt = (i_r + LW'(1) == fill_r) ? S_RS_END : S_RS_A;
        end
      end
      S_RS_MW: begin
        if (ar_done) begin
          cnt_nxt = cnt_r + CW'(1);
          sum_nxt = sum_r + UW'(accv_r);
          sq_nxt  = sq_r + QSW'(ar_res[2*SW-1:0]);
          i_nxt   = i_r + LW'(1);
          st_nxt  = (i_r + LW'(1) == fill_r) ? S_RS_END : S_RS_A;
        end
      end
      S_RS_END: begin
        fill_nxt = '0;
        done_nxt = 1'b1;
        bsum_nxt = '0;
        bsq_nxt  = '0;
        accv_nxt = smp_r;
        pend_nxt = 1'b0;
        st_nxt   = pend_r ? S_AC_G : S_RES;
      end
      S_AC_G: begin
        if (cnt_r != mcsa_pkg::COUNT_MAX) begin
          req.start = 1'b1;
          op_a      = AW'(mag_acc);
          op_b      = BW'(mag_acc);
          st_nxt    = S_AC_W;
        end else begin
          st_nxt = S_RES;
        end
      end
      S_AC_W: begin
        if (ar_done) begin
          cnt_nxt = cnt_r + CW'(1);
          sum_nxt = sum_r + UW'(accv_r);
          sq_nxt  = sq_r + QSW'(ar_res[2*SW-1:0]);
          st_nxt  = S_RES;
        end
      end
      S_RES: begin
        if (cnt_r == '0) begin
          mean_nxt = '0;
          st_nxt   = S_SGR;
        end else begin
          req.start = 1'b1;
          req.op    = mcsa_pkg::OP_DIV;
          op_a      = AW'({mag_sum, {FW{1'b0}}}) + AW'(mean_div);
          op_b      = BW'(cnt_r);
          st_nxt    = S_MN_W;
        end
      end
      S_MN_W: begin
        if (ar_done) begin
          mean_nxt = sum_r[UW-1] ? OW'(-ar_res[OW-1:0]) : ar_res[OW-1:0];
          st_nxt   = S_SGR;
        end
      end
      S_SGR: begin
        if (cnt_r < CW'(2)) begin
          std_nxt = '0;
          st_nxt  = S_OUT;
        end else begin
          sgn_nxt   = cnt_r;
          sgs_nxt   = sum_r;
          sgs2_nxt  = sq_r;
          sgfin_nxt = 1'b0;
          st_nxt    = S_SG_M1G;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          o_acc_nxt  = cnt_r;
          o_rej_nxt  = (seen_r > cnt_r) ? seen_r - cnt_r : '0;
          o_mean_nxt = mean_r;
          o_std_nxt  = std_r;
          o_lo_nxt   = low_r;
          o_hi_nxt   = high_r;
          o_set_nxt  = done_r;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      min_r  <= MIN_RST;
      max_r  <= MAX_RST;
      init_r <= 9'(mcsa_pkg::INIT_DEPTH);
      devs_r <= 4'd3;
      fill_r <= '0;
      done_r <= 1'b0;
      low_r  <= {MIN_RST, {FW{1'b0}}};
      high_r <= {MAX_RST, {FW{1'b0}}};
      seen_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      sq_r   <= '0;
      bsum_r <= '0;
      bsq_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      init_r <= init_nxt;
      devs_r <= devs_nxt;
      fill_r <= fill_nxt;
      done_r <= done_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      seen_r <= seen_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
      bsum_r <= bsum_nxt;
      bsq_r  <= bsq_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
    accv_r   <= accv_nxt;
    smp_r    <= smp_nxt;
    cand_r   <= cand_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    less_r   <= less_nxt;
    le_r     <= le_nxt;
    sgn_r    <= sgn_nxt;
    sgs_r    <= sgs_nxt;
    sgs2_r   <= sgs2_nxt;
    sgfin_r  <= sgfin_nxt;
    num_r    <= num_nxt;
    den_r    <= den_nxt;
    quot_r   <= quot_nxt;
    root_r   <= root_nxt;
    med_r    <= med_nxt;
    mean_r   <= mean_nxt;
    std_r    <= std_nxt;
    o_acc_r  <= o_acc_nxt;
    o_rej_r  <= o_rej_nxt;
    o_mean_r <= o_mean_nxt;
    o_std_r  <= o_std_nxt;
    o_lo_r   <= o_lo_nxt;
    o_hi_r   <= o_hi_nxt;
    o_set_r  <= o_set_nxt;
  end

  assign out_valid          = ov_r;
  assign out_accepted_count = o_acc_r;
  assign out_rejected_count = o_rej_r;
  assign out_mean           = o_mean_r;
  assign out_std_dev        = o_std_r;
  assign out_lower_limit    = o_lo_r;
  assign out_upper_limit    = o_hi_r;
  assign out_limits_set     = o_set_r;

  a_limits_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> $stable(low_r) && $stable(high_r))
    else $error("limits changed after clipping was done");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LW'(mcsa_pkg::INIT_DEPTH))
    else $error("buffer fill beyond depth");

  a_count_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= seen_r)
    else $error("accumulator count exceeds samples seen");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall && !cfg_ready)
    else $error("input or config open while sequencer busy");

endmodule
